/* src/sorted_record_table_top_defines.svh */
`ifndef SORTED_RECORD_TABLE_TOP_DEFINES_SVH
`define SORTED_RECORD_TABLE_TOP_DEFINES_SVH

// check cons in the same cycle as ante
`define SRT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srt: same-cycle check failed");

// check cons in the cycle after ante
`define SRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srt: next-cycle check failed");

`endif

/* src/srt_pkg.sv */
package srt_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int KEY_W   = 16;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 5;
    localparam int REC_W   = KEY_W + YEAR_W + MONTH_W + DAY_W;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_INS_PUT,
        S_DEL
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } record_t;

endpackage

/* src/sorted_record_table_top.sv */
// channel | signals                                              | handshake
// --------+------------------------------------------------------+-------------------------
// command | operation record_key date_year date_month date_day   | start & !busy
// result  | status record_count                                  | done, one cycle, no stall
//
// Insert into a table of n records: done straight from idle when empty or full, else a walk
// down from the top, one entry read and moved per cycle through the record RAM port.
// Delete: done straight from idle when empty, else a scan of all n entries, one per cycle.
// The result word is registered from the last step; busy drops as it appears.
// Reset clears the fill count and control state only; RAM contents stay undefined.
// The receiver cannot stall: done is high for exactly one cycle per command word.
`include "sorted_record_table_top_defines.svh"

module sorted_record_table_top #(
    parameter int CAPACITY = srt_pkg::CAPACITY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic [srt_pkg::KEY_W-1:0]    record_key,
    input  logic [srt_pkg::YEAR_W-1:0]   date_year,
    input  logic [srt_pkg::MONTH_W-1:0]  date_month,
    input  logic [srt_pkg::DAY_W-1:0]    date_day,
    output logic                         done,
    output logic [srt_pkg::STAT_W-1:0]   status,
    output logic [srt_pkg::CNT_W-1:0]    record_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    srt_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic             found_reg, found_next;
    srt_pkg::record_t new_rec_reg, new_rec_next;
    logic             done_reg, done_next;
    srt_pkg::status_t status_reg, status_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    srt_pkg::record_t ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [srt_pkg::REC_W-1:0] ram_rdata;
    srt_pkg::record_t rd_rec;
    srt_pkg::record_t in_rec;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic             ins_shift;
    logic             del_match;
    logic             del_last;
    logic [AW-1:0]    last_addr;

    srt_ram #(
        .WIDTH (srt_pkg::REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_rec    = srt_pkg::record_t'(ram_rdata);
    assign in_rec    = '{key: record_key, year: date_year, month: date_month, day: date_day};
    assign accept    = start && (state_reg == srt_pkg::S_IDLE);
    assign is_full   = (count_reg == CW'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign last_addr = AW'(count_reg - 1'b1);
    assign ins_shift = (rd_rec.key >= new_rec_reg.key);
    assign del_match = !found_reg && (rd_rec.key == new_rec_reg.key);
    assign del_last  = (ptr_reg == last_addr);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srt_pkg::S_IDLE:
            begin
                if (accept && !is_empty)
                begin
                    if (operation == srt_pkg::OP_DELETE)
                    begin
                        state_next = srt_pkg::S_DEL;
                    end
                    else if (!is_full)
                    begin
                        state_next = srt_pkg::S_INS;
                    end
                end
            end
            srt_pkg::S_INS:
            begin
                if (!ins_shift)
                begin
                    state_next = srt_pkg::S_IDLE;
                end
                else if (ptr_reg == AW'(1))
                begin
                    state_next = srt_pkg::S_INS_PUT;
                end
            end
            srt_pkg::S_INS_PUT:
            begin
                state_next = srt_pkg::S_IDLE;
            end
            srt_pkg::S_DEL:
            begin
                if (del_last)
                begin
                    state_next = srt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        found_next   = found_reg;
        new_rec_next = new_rec_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = ptr_reg;
        ram_wdata    = new_rec_reg;
        ram_raddr    = ptr_reg;
        case (state_reg)
            srt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    new_rec_next = in_rec;
                    found_next   = 1'b0;
                    if (operation == srt_pkg::OP_DELETE)
                    begin
                        ptr_next  = '0;
                        ram_raddr = '0;
                        if (is_empty)
                        begin
                            done_next   = 1'b1;
                            status_next = srt_pkg::ST_EMPTY;
                        end
                    end
                    else if (is_full)
                    begin
                        done_next   = 1'b1;
                        status_next = srt_pkg::ST_FULL;
                    end
                    else if (is_empty)
                    begin
                        // drop straight into the first slot
                        ram_we      = 1'b1;
                        ram_waddr   = '0;
                        ram_wdata   = in_rec;
                        count_next  = CW'(1);
                        done_next   = 1'b1;
                        status_next = srt_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        ptr_next  = AW'(count_reg);
                        ram_raddr = last_addr;
                    end
                end
            end
            srt_pkg::S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                if (ins_shift)
                begin
                    // move entry up one place, fetch the one below
                    ram_wdata = rd_rec;
                    ptr_next  = AW'(ptr_reg - 1'b1);
                    ram_raddr = AW'(ptr_reg - 2'd2);
                end
                else
                begin
                    ram_wdata   = new_rec_reg;
                    count_next  = CW'(count_reg + 1'b1);
                    done_next   = 1'b1;
                    status_next = srt_pkg::ST_INSERTED;
                end
            end
            srt_pkg::S_INS_PUT:
            begin
                ram_we      = 1'b1;
                ram_waddr   = ptr_reg;
                ram_wdata   = new_rec_reg;
                count_next  = CW'(count_reg + 1'b1);
                done_next   = 1'b1;
                status_next = srt_pkg::ST_INSERTED;
            end
            srt_pkg::S_DEL:
            begin
                // close the gap behind the deleted entry
                ram_we    = found_reg;
                ram_waddr = AW'(ptr_reg - 1'b1);
                ram_wdata = rd_rec;
                if (del_last)
                begin
                    done_next = 1'b1;
                    if (found_reg || del_match)
                    begin
                        count_next  = CW'(count_reg - 1'b1);
                        status_next = srt_pkg::ST_DELETED;
                    end
                    else
                    begin
                        status_next = srt_pkg::ST_NOT_FOUND;
                    end
                end
                else
                begin
                    ptr_next   = AW'(ptr_reg + 1'b1);
                    ram_raddr  = AW'(ptr_reg + 1'b1);
                    found_next = found_reg || del_match;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srt_pkg::S_IDLE;
            count_reg <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        new_rec_reg <= new_rec_next;
        status_reg  <= status_next;
    end

    assign busy         = (state_reg != srt_pkg::S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign record_count = srt_pkg::CNT_W'(count_reg);

    `SRT_ASSERT_SAME(a_done_not_busy, done_reg, state_reg == srt_pkg::S_IDLE)
    `SRT_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY))
    `SRT_ASSERT_SAME(a_busy_nonempty, state_reg != srt_pkg::S_IDLE, count_reg != '0)
    `SRT_ASSERT_NEXT(a_full_reject,
        accept && (operation == srt_pkg::OP_INSERT) && is_full,
        done_reg && (status_reg == srt_pkg::ST_FULL))
    `SRT_ASSERT_SAME(a_insert_count,
        done_reg && (status_reg == srt_pkg::ST_INSERTED),
        count_reg == CW'($past(count_reg) + 1'b1))

endmodule

/* src/srt_ram.sv */
module srt_ram #(
    parameter int WIDTH = srt_pkg::REC_W,
    parameter int DEPTH = srt_pkg::CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* test/sorted_record_table_top_test.sv */
`timescale 1ns / 100ps

module sorted_record_table_top_test;

    localparam int CAPACITY     = srt_pkg::CAPACITY_DEF;
    localparam int RANDOM_WORDS = 1300;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_EVERY  = 250;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        srt_pkg::op_t                op;
        logic [srt_pkg::KEY_W-1:0]   key;
        logic [srt_pkg::YEAR_W-1:0]  year;
        logic [srt_pkg::MONTH_W-1:0] month;
        logic [srt_pkg::DAY_W-1:0]   day;
        logic                        typed;
        srt_pkg::status_t            st;
        logic [srt_pkg::CNT_W-1:0]   cnt;
    } step_t;

    typedef struct packed {
        srt_pkg::status_t          st;
        logic [srt_pkg::CNT_W-1:0] cnt;
    } reply_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        operation;
    logic [srt_pkg::KEY_W-1:0]   record_key;
    logic [srt_pkg::YEAR_W-1:0]  date_year;
    logic [srt_pkg::MONTH_W-1:0] date_month;
    logic [srt_pkg::DAY_W-1:0]   date_day;
    logic                        done;
    logic [srt_pkg::STAT_W-1:0]  status;
    logic [srt_pkg::CNT_W-1:0]   record_count;

    logic [srt_pkg::KEY_W-1:0] shadow_keys [$];
    reply_t                    pending_replies [$];
    int                        errors = 0;
    int                        cycles = 0;

    step_t directed_steps [0:24] = '{
        '{srt_pkg::OP_DELETE, 16'h0000, 14'd0, 4'd1, 5'd1, 1'b1, srt_pkg::ST_EMPTY, 5'd0},
        '{srt_pkg::OP_DELETE, 16'hFFFF, 14'd16383, 4'd15, 5'd31, 1'b1, srt_pkg::ST_EMPTY, 5'd0},
        '{srt_pkg::OP_INSERT, 16'h0000, 14'd0, 4'd1, 5'd1, 1'b1, srt_pkg::ST_INSERTED, 5'd1},
        '{srt_pkg::OP_INSERT, 16'hFFFF, 14'd9999, 4'd12, 5'd31, 1'b1, srt_pkg::ST_INSERTED, 5'd2},
        '{srt_pkg::OP_INSERT, 16'h0000, 14'd16383, 4'd15, 5'd31, 1'b1, srt_pkg::ST_INSERTED, 5'd3},
        '{srt_pkg::OP_DELETE, 16'h1234, 14'd0, 4'd0, 5'd0, 1'b1, srt_pkg::ST_NOT_FOUND, 5'd3},
        '{srt_pkg::OP_DELETE, 16'h0000, 14'd0, 4'd0, 5'd0, 1'b1, srt_pkg::ST_DELETED, 5'd2},
        '{srt_pkg::OP_INSERT, 16'h8000, 14'd0, 4'd0, 5'd0, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'h4000, 14'd2024, 4'd6, 5'd15, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'hC000, 14'd1, 4'd2, 5'd28, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'h8000, 14'd8191, 4'd7, 5'd16, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'h0001, 14'd5461, 4'd10, 5'd10, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'hFFFE, 14'd10922, 4'd5, 5'd21, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'h2AAA, 14'd1999, 4'd3, 5'd3, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'hD555, 14'd9998, 4'd11, 5'd30, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'h8000, 14'd4096, 4'd8, 5'd8, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'h7FFF, 14'd1234, 4'd4, 5'd4, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'h8001, 14'd3000, 4'd9, 5'd9, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'h0100, 14'd42, 4'd1, 5'd2, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'hFF00, 14'd7777, 4'd12, 5'd1, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'h1000, 14'd600, 4'd6, 5'd6, 1'b0, srt_pkg::ST_INSERTED, 5'd0},
        '{srt_pkg::OP_INSERT, 16'h5555, 14'd5555, 4'd5, 5'd5, 1'b1, srt_pkg::ST_FULL, 5'd16},
        '{srt_pkg::OP_DELETE, 16'hFFFF, 14'd0, 4'd0, 5'd0, 1'b1, srt_pkg::ST_DELETED, 5'd15},
        '{srt_pkg::OP_DELETE, 16'h0000, 14'd0, 4'd0, 5'd0, 1'b1, srt_pkg::ST_DELETED, 5'd14},
        '{srt_pkg::OP_DELETE, 16'h5555, 14'd0, 4'd0, 5'd0, 1'b1, srt_pkg::ST_NOT_FOUND, 5'd14}
    };

    sorted_record_table_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .record_key   (record_key),
        .date_year    (date_year),
        .date_month   (date_month),
        .date_day     (date_day),
        .done         (done),
        .status       (status),
        .record_count (record_count)
    );

    always #5 clk = ~clk;

    task automatic flag_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic reply_t apply_record_op(input srt_pkg::op_t op,
                                               input logic [srt_pkg::KEY_W-1:0] key);
        reply_t r;
        int     pos = 0;
        if (op == srt_pkg::OP_INSERT)
        begin
            if (shadow_keys.size() >= CAPACITY)
            begin
                r.st = srt_pkg::ST_FULL;
            end
            else
            begin
                while (pos < shadow_keys.size() && key > shadow_keys[pos])
                    pos++;
                shadow_keys.insert(pos, key);
                r.st = srt_pkg::ST_INSERTED;
            end
        end
        else if (shadow_keys.size() == 0)
        begin
            r.st = srt_pkg::ST_EMPTY;
        end
        else
        begin
            while (pos < shadow_keys.size() && shadow_keys[pos] != key)
                pos++;
            if (pos >= shadow_keys.size())
            begin
                r.st = srt_pkg::ST_NOT_FOUND;
            end
            else
            begin
                shadow_keys.delete(pos);
                r.st = srt_pkg::ST_DELETED;
            end
        end
        r.cnt = srt_pkg::CNT_W'(shadow_keys.size());
        return r;
    endfunction

    task automatic send_word(input step_t w);
        reply_t r;
        @(negedge clk);
        operation  <= w.op;
        record_key <= w.key;
        date_year  <= w.year;
        date_month <= w.month;
        date_day   <= w.day;
        start      <= 1'b1;
        while (busy !== 1'b0)
            @(negedge clk);
        @(posedge clk);
        r = apply_record_op(w.op, w.key);
        if (w.typed)
        begin
            r.st  = w.st;
            r.cnt = w.cnt;
        end
        pending_replies.push_back(r);
    endtask

    task automatic idle_burst(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start      <= 1'b0;
            operation  <= 1'($urandom_range(0, 1));
            record_key <= srt_pkg::KEY_W'($urandom);
            date_year  <= srt_pkg::YEAR_W'($urandom);
            date_month <= srt_pkg::MONTH_W'($urandom);
            date_day   <= srt_pkg::DAY_W'($urandom);
        end
    endtask

    function automatic logic [srt_pkg::KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return srt_pkg::KEY_W'($urandom_range(0, 15));
        if (sel == 5)
            return '0;
        if (sel == 6)
            return '1;
        return srt_pkg::KEY_W'($urandom);
    endfunction

    function automatic step_t random_step(input int insert_pct);
        step_t w;
        w = '0;
        if ($urandom_range(0, 99) < insert_pct)
        begin
            w.op  = srt_pkg::OP_INSERT;
            w.key = pick_key();
        end
        else
        begin
            w.op = srt_pkg::OP_DELETE;
            if (shadow_keys.size() != 0 && $urandom_range(0, 3) != 0)
                w.key = shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
            else
                w.key = pick_key();
        end
        w.year  = ($urandom_range(0, 4) != 0) ? srt_pkg::YEAR_W'($urandom_range(0, 9999))
                                               : srt_pkg::YEAR_W'($urandom);
        w.month = ($urandom_range(0, 9) != 0) ? srt_pkg::MONTH_W'($urandom_range(1, 12))
                                               : srt_pkg::MONTH_W'($urandom);
        w.day   = ($urandom_range(0, 9) != 0) ? srt_pkg::DAY_W'($urandom_range(1, 31))
                                               : srt_pkg::DAY_W'($urandom);
        return w;
    endfunction

    always @(posedge clk)
    begin : word_check
        reply_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected word status=%0d count=%0d",
                                        status, record_count));
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.st)
                    flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
                if (record_count !== want.cnt)
                    flag_mismatch($sformatf("record_count %0d, want %0d",
                                            record_count, want.cnt));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sorted_record_table_top test failed");
            $finish;
        end
    end

    initial
    begin
        int seg_left;
        int insert_pct;
        int gap_pct;
        seg_left   = 0;
        insert_pct = 50;
        gap_pct    = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = 1'b0;
        record_key = '0;
        date_year  = '0;
        date_month = '0;
        date_day   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
            send_word(directed_steps[i]);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(16, 48);
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
            end
            seg_left--;
            if (i % DRAIN_EVERY == DRAIN_EVERY / 2)
            begin
                // hold until every outstanding word has come back
                idle_burst(1);
                while (pending_replies.size() != 0)
                    @(negedge clk);
            end
            if (i < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 99) < gap_pct)
                idle_burst($urandom_range(1, 12));
            send_word(random_step(insert_pct));
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0)
            $display("sorted_record_table_top test passed");
        else
            $display("sorted_record_table_top test failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/srt_pkg.sv
src/srt_ram.sv
src/sorted_record_table_top.sv
test/sorted_record_table_top_test.sv
